FILE: rtl/clnasm_pkg.sv
package clnasm_pkg;

    localparam int BYTE_W = 8;
    localparam int CHAR_W = 7;

    localparam logic [BYTE_W-1:0] CODE_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_DEL      = 8'h7F;
    localparam logic [BYTE_W-1:0] CODE_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_PRINT_LO = 8'h20;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_TOO_LONG = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef struct packed {
        logic term;
        logic erase;
        logic print;
    } byte_kind_t;

endpackage

FILE: rtl/console_line_assembler_core.sv
// an error result is offered in the cycle after its input beat is taken
// a completed line is read out of the line store one character at a time,
// through S_FETCH at the single registered read port, then S_LOAD; the input
// is stalled until the last character has been loaded into the output register
// other beats are taken one per cycle while the output register can drain
// reset (rst_n, async, active low) empties the line and the output register
module console_line_assembler_core #(
    parameter int LINE_MAX = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic                          command,
    input  logic [clnasm_pkg::BYTE_W-1:0] received_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output clnasm_pkg::kind_t             kind,
    output logic [clnasm_pkg::CHAR_W-1:0] line_char,
    output logic                          last
);
    import clnasm_pkg::*;

    localparam int LINE_CAP = LINE_MAX - 1;
    localparam int LW       = $clog2(LINE_MAX);
    localparam int IW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
    localparam logic [LW-1:0] CAP_LEN = LW'(LINE_CAP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t            state_reg,  state_next;
    logic [LW-1:0]     length_reg, length_next;
    logic [IW-1:0]     idx_reg,    idx_next;
    logic              valid_reg,  valid_next;
    kind_t             kind_reg,   kind_next;
    logic [CHAR_W-1:0] char_reg,   char_next;
    logic              last_reg,   last_next;

    byte_kind_t        byte_kind;
    logic              accept;
    logic              out_free;
    logic              wr_en;
    logic              rd_en;
    logic [CHAR_W-1:0] rd_data;
    logic              at_end;

    clnasm_classify u_classify (
        .data      (received_byte),
        .byte_kind (byte_kind)
    );

    clnasm_store #(
        .DEPTH (LINE_CAP),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (length_reg[IW-1:0]),
        .wr_data (received_byte[CHAR_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign out_free   = !valid_reg || !result_stall;
    assign byte_stall = (state_reg != S_IDLE) || !out_free;
    assign accept     = byte_valid && !byte_stall;
    assign at_end     = (LW'(idx_reg) == (length_reg - 1'b1));

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && result_stall;
        kind_next   = kind_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command)
                    begin
                        length_next = '0;
                        valid_next  = 1'b1;
                        kind_next   = KIND_OVERFLOW;
                        char_next   = '0;
                        last_next   = 1'b1;
                    end
                    else if (byte_kind.term)
                    begin
                        if (length_reg != '0)
                        begin
                            idx_next   = '0;
                            state_next = S_FETCH;
                        end
                    end
                    else if (byte_kind.erase)
                    begin
                        if (length_reg != '0)
                        begin
                            length_next = length_reg - 1'b1;
                        end
                    end
                    else if (length_reg == CAP_LEN)
                    begin
                        length_next = '0;
                        valid_next  = 1'b1;
                        kind_next   = KIND_TOO_LONG;
                        char_next   = '0;
                        last_next   = 1'b1;
                    end
                    else if (byte_kind.print)
                    begin
                        wr_en       = 1'b1;
                        length_next = length_reg + 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_CHAR;
                    char_next  = rd_data;
                    last_next  = at_end;
                    if (at_end)
                    begin
                        length_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign line_char    = char_reg;
    assign last         = last_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= CAP_LEN)
        else $error("line length beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (length_reg != '0) && !wr_en)
        else $error("emitting an empty line or writing during readout");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg != KIND_CHAR)) |-> (last_reg && (char_reg == '0)))
        else $error("error beat without last or with a character");

    a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> (length_reg == '0) && valid_reg
            && (kind_reg == KIND_OVERFLOW))
        else $error("overflow command did not clear the line");

endmodule

FILE: rtl/clnasm_classify.sv
module clnasm_classify (
    input  logic [clnasm_pkg::BYTE_W-1:0] data,
    output clnasm_pkg::byte_kind_t        byte_kind
);
    import clnasm_pkg::*;

    always_comb
    begin
        byte_kind.term  = (data == CODE_LF) || (data == CODE_CR);
        byte_kind.erase = (data == CODE_BS) || (data == CODE_DEL);
        byte_kind.print = (data >= CODE_PRINT_LO) && (data < CODE_DEL);
    end

endmodule

FILE: rtl/clnasm_store.sv
module clnasm_store #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [clnasm_pkg::CHAR_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [clnasm_pkg::CHAR_W-1:0] rd_data
);
    import clnasm_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
